FILE: design/slc_pkg.sv
// shared constants, types and the per-set lookup function of the cache model
`default_nettype none

package slc_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_W       = 48;

    localparam int SETS    = 1 << MAX_SET_BITS;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
    localparam int SHIFT_W = 7;

    // configuration port
    localparam int SET_BITS_W   = 4;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_FETCH  = 2'd3;

    // lookup outcomes
    localparam logic [1:0] RES_HIT     = 2'd0;
    localparam logic [1:0] RES_MISS    = 2'd1;
    localparam logic [1:0] RES_EVICT   = 2'd2;
    localparam logic [1:0] RES_IGNORED = 2'd3;

    // one memory row holds every way of a set
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        row_t       row;
        logic [1:0] res;
    } lookup_t;

    // one lookup on a set: hit check, fill or eviction, lru rank update
    function automatic lookup_t lookup_row(input row_t row, input logic [ADDR_W-1:0] tag,
                                           input logic [WAYS_W-1:0] ways);
        logic [MAX_WAYS-1:0] in_use;
        logic [MAX_WAYS-1:0] hit;
        logic [MAX_WAYS-1:0] free;
        logic                found;
        logic                have_free;
        logic [RANK_W-1:0]   u;
        logic [RANK_W+1:0]   old_rank;
        logic [1:0]          res;
        lookup_t             r;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = (ways > WAYS_W'(w));
            hit[w]    = in_use[w] && row.valid[w] && (row.tag[w] == tag);
            free[w]   = in_use[w] && !row.valid[w];
        end
        found     = |hit;
        have_free = |free;
        u         = '0;
        if (found)
        begin
            for (int w = MAX_WAYS - 1; w >= 0; w--)
            begin
                if (hit[w])
                begin
                    u = RANK_W'(w);
                end
            end
            old_rank = {2'b00, row.rank[u]};
            res      = RES_HIT;
        end
        else if (have_free)
        begin
            for (int w = MAX_WAYS - 1; w >= 0; w--)
            begin
                if (free[w])
                begin
                    u = RANK_W'(w);
                end
            end
            old_rank = (RANK_W + 2)'(MAX_WAYS + 1);
            res      = RES_MISS;
        end
        else
        begin
            // oldest way, lowest number among equal ranks
            for (int w = 1; w < MAX_WAYS; w++)
            begin
                if (in_use[w] && (row.rank[w] > row.rank[u]))
                begin
                    u = RANK_W'(w);
                end
            end
            old_rank = {2'b00, row.rank[u]};
            res      = RES_EVICT;
        end
        r.row = row;
        if (!found)
        begin
            r.row.valid[u] = 1'b1;
            r.row.tag[u]   = tag;
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if ((RANK_W'(w) != u) && in_use[w] && row.valid[w]
                && ({2'b00, row.rank[w]} < old_rank)
                && (row.rank[w] < RANK_W'(MAX_WAYS - 1)))
            begin
                r.row.rank[w] = row.rank[w] + 1'b1;
            end
        end
        r.row.rank[u] = '0;
        r.res         = res;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/set_assoc_lru_cache_sim_core.sv
// top level of the set-associative lru cache model
//
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  kind, address
// out       output     out_valid/out_stall outcome, modify_second_hit, hit/miss/eviction_total
// cfg       input      cfg_wr_en          cfg_addr, cfg_wdata
//
// every access passes address split and set read, one read-modify-write of the set row per
// lookup (a load or store has one lookup, a modify two, a fetch none) and the result step.
// the set row memory has one read and one write port; the modify's second lookup works
// on the row just written, held in a register.
// reset clears the totals and one valid flag per set row, zeroes the set and block bits and sets
// ways in use to 1; no sweep. a result waiting under out_stall holds the block only when the next result is ready.
`default_nettype none

module set_assoc_lru_cache_sim_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [slc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [slc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     kind,
    input  wire logic [slc_pkg::ADDR_W-1:0]     address,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [1:0]                     outcome,
    output logic                                modify_second_hit,
    output logic      [31:0]                    hit_total,
    output logic      [31:0]                    miss_total,
    output logic      [31:0]                    eviction_total
);

    import slc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_UPD2  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [SET_BITS_W-1:0]   set_index_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_offset_bits_reg;
    logic [WAYS_CFG_W-1:0]   ways_in_use_reg;
    logic [1:0]              kind_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [SET_W-1:0]        set_reg;
    logic [ADDR_W-1:0]       tag_reg;
    logic                    row_vld_q_reg;
    logic [SETS-1:0]         row_vld_reg;
    row_t                    row_reg;
    logic [1:0]              res1_reg;
    logic                    second_reg;
    logic [31:0]             hits_reg, misses_reg, evictions_reg;
    logic                    out_valid_reg;
    logic [1:0]              outcome_reg;
    logic                    second_out_reg;
    logic [31:0]             hit_out_reg, miss_out_reg, evict_out_reg;

    logic                    in_xfer;
    logic                    done_go;
    logic [SET_BITS_W-1:0]   sb_eff;
    logic [SHIFT_W-1:0]      tag_shift;
    logic [ADDR_W-1:0]       addr_sh_blk;
    logic [SET_W-1:0]        set_ones_sh;
    logic [SET_W-1:0]        set_calc;
    logic [ADDR_W-1:0]       tag_calc;
    logic [WAYS_W-1:0]       ways_eff;
    logic [ROW_W-1:0]        ram_rdata;
    row_t                    row_in;
    lookup_t                 lk1, lk2;
    logic                    count_en;
    logic [1:0]              cur_res;
    logic                    ram_we;

    // ---------------- handshake ----------------
    assign done_go  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = !((state_reg == S_IDLE) || done_go);
    assign in_xfer  = in_valid && !in_stall;

    // ---------------- address split ----------------
    assign sb_eff      = (set_index_bits_reg > SET_BITS_W'(MAX_SET_BITS))
                         ? SET_BITS_W'(MAX_SET_BITS) : set_index_bits_reg;
    assign tag_shift   = SHIFT_W'(sb_eff) + SHIFT_W'(block_offset_bits_reg);
    assign addr_sh_blk = addr_reg >> block_offset_bits_reg;
    assign set_ones_sh = {SET_W{1'b1}} << sb_eff;
    assign set_calc    = (SHIFT_W'(block_offset_bits_reg) < SHIFT_W'(ADDR_W))
                         ? (addr_sh_blk[SET_W-1:0] & ~set_ones_sh) : '0;
    assign tag_calc    = (tag_shift < SHIFT_W'(ADDR_W)) ? (addr_reg >> tag_shift) : '0;

    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (WAYS_W'(ways_in_use_reg) > WAYS_W'(MAX_WAYS))
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(ways_in_use_reg);
        end
    end

    // ---------------- set row memory ----------------
    assign ram_we = (state_reg == S_UPD) || (state_reg == S_UPD2);

    slc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata ((state_reg == S_UPD) ? lk1.row : lk2.row),
        .re    (state_reg == S_SPLIT),
        .raddr (set_calc),
        .rdata (ram_rdata)
    );

    // a row never written reads as all invalid with rank zero
    assign row_in = row_vld_q_reg ? row_t'(ram_rdata) : '0;
    assign lk1    = lookup_row(row_in, tag_reg, ways_eff);
    assign lk2    = lookup_row(row_reg, tag_reg, ways_eff);

    assign count_en = ram_we;
    assign cur_res  = (state_reg == S_UPD) ? lk1.res : lk2.res;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                state_next = (kind_reg == KIND_FETCH) ? S_DONE : S_UPD;
            end
            S_UPD:
            begin
                state_next = (kind_reg == KIND_MODIFY) ? S_UPD2 : S_DONE;
            end
            S_UPD2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    state_next = in_xfer ? S_SPLIT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            set_index_bits_reg    <= '0;
            block_offset_bits_reg <= '0;
            ways_in_use_reg       <= WAYS_CFG_W'(1);
            row_vld_reg           <= '0;
            hits_reg              <= '0;
            misses_reg            <= '0;
            evictions_reg         <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_SET_BITS:   set_index_bits_reg    <= cfg_wdata[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_offset_bits_reg <= cfg_wdata[BLOCK_BITS_W-1:0];
                    CFG_WAYS:       ways_in_use_reg       <= cfg_wdata[WAYS_CFG_W-1:0];
                    default:        ;
                endcase
            end
            if (state_reg == S_UPD)
            begin
                row_vld_reg[set_reg] <= 1'b1;
            end
            if (count_en)
            begin
                if (cur_res == RES_HIT)
                begin
                    if (hits_reg != '1)
                    begin
                        hits_reg <= hits_reg + 32'd1;
                    end
                end
                else if (misses_reg != '1)
                begin
                    misses_reg <= misses_reg + 32'd1;
                end
                if ((cur_res == RES_EVICT) && (evictions_reg != '1))
                begin
                    evictions_reg <= evictions_reg + 32'd1;
                end
            end
            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind;
            addr_reg <= address;
        end
        if (state_reg == S_SPLIT)
        begin
            set_reg       <= set_calc;
            tag_reg       <= tag_calc;
            row_vld_q_reg <= row_vld_reg[set_calc];
            res1_reg      <= RES_IGNORED;
            second_reg    <= 1'b0;
        end
        if (state_reg == S_UPD)
        begin
            row_reg  <= lk1.row;
            res1_reg <= lk1.res;
        end
        if (state_reg == S_UPD2)
        begin
            second_reg <= (lk2.res == RES_HIT);
        end
        if (done_go)
        begin
            outcome_reg    <= res1_reg;
            second_out_reg <= second_reg;
            hit_out_reg    <= hits_reg;
            miss_out_reg   <= misses_reg;
            evict_out_reg  <= evictions_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign outcome           = outcome_reg;
    assign modify_second_hit = second_out_reg;
    assign hit_total         = hit_out_reg;
    assign miss_total        = miss_out_reg;
    assign eviction_total    = evict_out_reg;

    // ---------------- assertions ----------------
    a_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD2) |-> (lk2.res == RES_HIT))
        else $error("second lookup of a modify missed");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((kind_reg == KIND_LOAD) || (kind_reg == KIND_STORE)
                    || (kind_reg == KIND_MODIFY)))
        else $error("set row written for an ignored access");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (hits_reg == $past(hits_reg)))
        else $error("hit total moved while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented outside the done step");

endmodule

`default_nettype wire

FILE: design/slc_ram.sv
// generic single-port-write, registered-read memory
`default_nettype none

module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
